>>> design/debounced_toggle_led_controller_defines.svh
// assertion macros for the debounced toggle led controller
// no dependencies; included by the top level
`ifndef DEBOUNCED_TOGGLE_LED_CONTROLLER_DEFINES_SVH
`define DEBOUNCED_TOGGLE_LED_CONTROLLER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define DTLC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define DTLC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/dtlc_pkg.sv
// types, constants and helpers for the debounced toggle led controller
// no dependencies
`timescale 1ns / 1ps

package dtlc_pkg;

    localparam int TICK_WIDTH = 16;
    localparam int CFG_WIDTH  = 16;
    localparam int IDX_WIDTH  = 3;

    typedef logic [TICK_WIDTH-1:0] tick_t;
    typedef logic [7:0]            count8_t;
    typedef logic [15:0]           word16_t;
    typedef logic [1:0]            mode_code_t;

    localparam tick_t TICK_MAX = '1;

    // configuration register indexes
    localparam logic [IDX_WIDTH-1:0] REG_DEBOUNCE_SAMPLES = 3'd0;
    localparam logic [IDX_WIDTH-1:0] REG_BLINK_HALF_TICKS = 3'd1;
    localparam logic [IDX_WIDTH-1:0] REG_BLINK_CYCLES     = 3'd2;
    localparam logic [IDX_WIDTH-1:0] REG_STUCK_LIMIT      = 3'd3;
    localparam logic [IDX_WIDTH-1:0] REG_AUTO_OFF_LIMIT   = 3'd4;
    localparam logic [IDX_WIDTH-1:0] REG_WARN_WINDOW      = 3'd5;
    localparam logic [IDX_WIDTH-1:0] REG_WARN_HALF_TICKS  = 3'd6;

    // configuration reset values
    localparam count8_t RST_DEBOUNCE_SAMPLES = 8'd3;
    localparam tick_t   RST_BLINK_HALF_TICKS = TICK_WIDTH'(5);
    localparam count8_t RST_BLINK_CYCLES     = 8'd3;
    localparam tick_t   RST_STUCK_LIMIT      = TICK_WIDTH'(500);
    localparam tick_t   RST_AUTO_OFF_LIMIT   = TICK_WIDTH'(1000);
    localparam tick_t   RST_WARN_WINDOW      = TICK_WIDTH'(300);
    localparam tick_t   RST_WARN_HALF_TICKS  = TICK_WIDTH'(2);

    // reported mode codes
    localparam mode_code_t CODE_OFF   = 2'd0;
    localparam mode_code_t CODE_BLINK = 2'd1;
    localparam mode_code_t CODE_ON    = 2'd2;

    typedef enum logic [2:0] {
        MODE_OFF   = 3'b001,
        MODE_BLINK = 3'b010,
        MODE_ON    = 3'b100
    } mode_t;

    // result beat, main_led in the lowest bit
    typedef struct packed {
        logic       mode_changed;
        logic       stuck_flag;
        word16_t    ticks_to_off;
        mode_code_t blink_goal;
        count8_t    blink_done_cycles;
        word16_t    presses;
        logic       button_stable;
        mode_code_t light_mode;
        logic       green_led;
        logic       main_led;
    } result_t;

    localparam int RESULT_WIDTH = $bits(result_t);
    localparam int OUT_WIDTH    = ((RESULT_WIDTH + 7) / 8) * 8;

    function automatic tick_t tick_inc(input tick_t v);
        tick_inc = (v == TICK_MAX) ? v : v + TICK_WIDTH'(1);
    endfunction

    function automatic mode_code_t mode_code(input mode_t m);
        case (m)
            MODE_BLINK: mode_code = CODE_BLINK;
            MODE_ON:    mode_code = CODE_ON;
            default:    mode_code = CODE_OFF;
        endcase
    endfunction

endpackage

>>> design/debounced_toggle_led_controller.sv
// debounced toggle led controller, top level
// depends on dtlc_pkg and debounced_toggle_led_controller_defines.svh
`timescale 1ns / 1ps

// One input beat (raw button level for one tick) gives exactly one result beat.
// A beat is taken every cycle: the whole tick update is done in the cycle of
// acceptance and the result goes into the output register. The rate is set
// only by the output register: a new beat is taken whenever that register is
// empty or is being drained in the same cycle. Configuration registers are
// written through cfg_wr_en/cfg_index/cfg_data, by the user only while idle
// (the block does not enforce it); indexes past the last register are ignored.
`include "debounced_toggle_led_controller_defines.svh"

module debounced_toggle_led_controller (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [dtlc_pkg::IDX_WIDTH-1:0]        cfg_index,
    input  logic [dtlc_pkg::CFG_WIDTH-1:0]        cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [7:0]                            s_axis_tdata,  // raw_button
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // main_led, green_led, light_mode, button_stable, presses,
    // blink_done_cycles, blink_goal, ticks_to_off, stuck_flag, mode_changed
    output logic [dtlc_pkg::OUT_WIDTH-1:0]        m_axis_tdata
);

    // configuration
    dtlc_pkg::count8_t debounce_samples_reg;
    dtlc_pkg::tick_t   blink_half_ticks_reg;
    dtlc_pkg::count8_t blink_cycles_reg;
    dtlc_pkg::tick_t   stuck_limit_reg;
    dtlc_pkg::tick_t   auto_off_limit_reg;
    dtlc_pkg::tick_t   warn_window_reg;
    dtlc_pkg::tick_t   warn_half_ticks_reg;

    // tick state
    dtlc_pkg::mode_t   mode_reg,        mode_next;
    dtlc_pkg::mode_t   goal_reg,        goal_next;
    dtlc_pkg::count8_t cycle_count_reg, cycle_count_next;
    dtlc_pkg::tick_t   blink_tick_reg,  blink_tick_next;
    logic              blink_phase_reg, blink_phase_next;
    dtlc_pkg::tick_t   idle_count_reg,  idle_count_next;
    dtlc_pkg::tick_t   held_count_reg,  held_count_next;
    logic              stuck_reg,       stuck_next;
    dtlc_pkg::word16_t press_total_reg, press_total_next;
    dtlc_pkg::tick_t   warn_tick_reg,   warn_tick_next;
    logic              warn_phase_reg,  warn_phase_next;
    logic              stable_reg,      stable_next;
    logic              candidate_reg,   candidate_next;
    dtlc_pkg::count8_t agree_count_reg, agree_count_next;
    logic              prior_stable_reg, prior_stable_next;

    // output stage
    dtlc_pkg::result_t result_reg, result_next;
    logic              out_valid_reg;

    logic              accept;
    logic              raw;
    logic              led;
    logic              green;
    logic              fired;
    logic              press;
    dtlc_pkg::tick_t   remain;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign raw           = s_axis_tdata[0];
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(dtlc_pkg::OUT_WIDTH - dtlc_pkg::RESULT_WIDTH)'(0), result_reg};

    always_comb
    begin
        mode_next         = mode_reg;
        goal_next         = goal_reg;
        cycle_count_next  = cycle_count_reg;
        blink_tick_next   = blink_tick_reg;
        blink_phase_next  = blink_phase_reg;
        idle_count_next   = idle_count_reg;
        held_count_next   = held_count_reg;
        stuck_next        = stuck_reg;
        press_total_next  = press_total_reg;
        warn_tick_next    = warn_tick_reg;
        warn_phase_next   = warn_phase_reg;
        stable_next       = stable_reg;
        candidate_next    = candidate_reg;
        agree_count_next  = agree_count_reg;
        fired             = 1'b0;
        remain            = '0;

        // blink sequence and led
        if (mode_reg == dtlc_pkg::MODE_BLINK)
        begin
            blink_tick_next = dtlc_pkg::tick_inc(blink_tick_reg);
            if (blink_tick_next >= blink_half_ticks_reg)
            begin
                blink_tick_next  = '0;
                blink_phase_next = !blink_phase_reg;
                if (!blink_phase_next && cycle_count_reg != 8'hFF)
                begin
                    cycle_count_next = cycle_count_reg + 8'd1;
                end
                if (cycle_count_next >= blink_cycles_reg)
                begin
                    mode_next = goal_reg;
                    led       = (goal_reg == dtlc_pkg::MODE_ON);
                end
                else
                begin
                    led = !blink_phase_next;
                end
            end
            else
            begin
                led = !blink_phase_reg;
            end
        end
        else
        begin
            led = (mode_reg == dtlc_pkg::MODE_ON);
        end

        // debounce
        if (raw == candidate_reg)
        begin
            if (agree_count_reg < debounce_samples_reg)
            begin
                agree_count_next = agree_count_reg + 8'd1;
            end
        end
        else
        begin
            candidate_next   = raw;
            agree_count_next = 8'd1;
        end
        if (agree_count_next >= debounce_samples_reg)
        begin
            stable_next = candidate_next;
        end
        press             = stable_next && !prior_stable_reg && (mode_next != dtlc_pkg::MODE_BLINK);
        prior_stable_next = stable_next;

        // stuck button
        if (raw)
        begin
            if (held_count_reg < stuck_limit_reg)
            begin
                held_count_next = dtlc_pkg::tick_inc(held_count_reg);
            end
            stuck_next = (held_count_next >= stuck_limit_reg);
        end
        else
        begin
            held_count_next = '0;
            stuck_next      = 1'b0;
        end

        if (press)
        begin
            press_total_next = press_total_reg + 16'd1;
        end

        // idle timeout
        if (mode_next == dtlc_pkg::MODE_ON)
        begin
            if (press)
            begin
                idle_count_next = '0;
            end
            else
            begin
                idle_count_next = dtlc_pkg::tick_inc(idle_count_reg);
                if (idle_count_next >= auto_off_limit_reg)
                begin
                    idle_count_next = '0;
                    mode_next       = dtlc_pkg::MODE_OFF;
                    fired           = 1'b1;
                    led             = 1'b0;
                end
            end
        end
        else
        begin
            idle_count_next = '0;
        end

        // press starts a blink toward the opposite state
        if (!fired && press)
        begin
            goal_next        = (mode_next == dtlc_pkg::MODE_OFF) ? dtlc_pkg::MODE_ON
                                                                 : dtlc_pkg::MODE_OFF;
            cycle_count_next = '0;
            blink_tick_next  = '0;
            blink_phase_next = 1'b0;
            mode_next        = dtlc_pkg::MODE_BLINK;
        end

        // green warning blink
        if (mode_next == dtlc_pkg::MODE_ON && auto_off_limit_reg > idle_count_next)
        begin
            remain = auto_off_limit_reg - idle_count_next;
        end
        if (mode_next == dtlc_pkg::MODE_ON && remain <= warn_window_reg)
        begin
            warn_tick_next = dtlc_pkg::tick_inc(warn_tick_reg);
            if (warn_tick_next >= warn_half_ticks_reg)
            begin
                warn_tick_next  = '0;
                warn_phase_next = !warn_phase_reg;
            end
            green = !warn_phase_next;
        end
        else
        begin
            warn_tick_next  = '0;
            warn_phase_next = 1'b0;
            green           = 1'b1;
        end

        result_next.main_led          = led;
        result_next.green_led         = green;
        result_next.light_mode        = dtlc_pkg::mode_code(mode_next);
        result_next.button_stable     = stable_next;
        result_next.presses           = press_total_next;
        result_next.blink_done_cycles = cycle_count_next;
        result_next.blink_goal        = dtlc_pkg::mode_code(goal_next);
        result_next.ticks_to_off      = 16'(remain);
        result_next.stuck_flag        = stuck_next;
        result_next.mode_changed      = (mode_next != mode_reg);
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_samples_reg <= dtlc_pkg::RST_DEBOUNCE_SAMPLES;
            blink_half_ticks_reg <= dtlc_pkg::RST_BLINK_HALF_TICKS;
            blink_cycles_reg     <= dtlc_pkg::RST_BLINK_CYCLES;
            stuck_limit_reg      <= dtlc_pkg::RST_STUCK_LIMIT;
            auto_off_limit_reg   <= dtlc_pkg::RST_AUTO_OFF_LIMIT;
            warn_window_reg      <= dtlc_pkg::RST_WARN_WINDOW;
            warn_half_ticks_reg  <= dtlc_pkg::RST_WARN_HALF_TICKS;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                dtlc_pkg::REG_DEBOUNCE_SAMPLES: debounce_samples_reg <= cfg_data[7:0];
                dtlc_pkg::REG_BLINK_HALF_TICKS: blink_half_ticks_reg <= cfg_data;
                dtlc_pkg::REG_BLINK_CYCLES:     blink_cycles_reg     <= cfg_data[7:0];
                dtlc_pkg::REG_STUCK_LIMIT:      stuck_limit_reg      <= cfg_data;
                dtlc_pkg::REG_AUTO_OFF_LIMIT:   auto_off_limit_reg   <= cfg_data;
                dtlc_pkg::REG_WARN_WINDOW:      warn_window_reg      <= cfg_data;
                dtlc_pkg::REG_WARN_HALF_TICKS:  warn_half_ticks_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // tick state, advanced once per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= dtlc_pkg::MODE_OFF;
            goal_reg         <= dtlc_pkg::MODE_ON;
            cycle_count_reg  <= '0;
            blink_tick_reg   <= '0;
            blink_phase_reg  <= 1'b0;
            idle_count_reg   <= '0;
            held_count_reg   <= '0;
            stuck_reg        <= 1'b0;
            press_total_reg  <= '0;
            warn_tick_reg    <= '0;
            warn_phase_reg   <= 1'b0;
            stable_reg       <= 1'b0;
            candidate_reg    <= 1'b0;
            agree_count_reg  <= '0;
            prior_stable_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg         <= mode_next;
            goal_reg         <= goal_next;
            cycle_count_reg  <= cycle_count_next;
            blink_tick_reg   <= blink_tick_next;
            blink_phase_reg  <= blink_phase_next;
            idle_count_reg   <= idle_count_next;
            held_count_reg   <= held_count_next;
            stuck_reg        <= stuck_next;
            press_total_reg  <= press_total_next;
            warn_tick_reg    <= warn_tick_next;
            warn_phase_reg   <= warn_phase_next;
            stable_reg       <= stable_next;
            candidate_reg    <= candidate_next;
            agree_count_reg  <= agree_count_next;
            prior_stable_reg <= prior_stable_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    `DTLC_ASSERT_NEXT(a_accept_gives_beat, accept, m_axis_tvalid, "accepted beat gave no result")
    `DTLC_ASSERT_NOW(a_stall_blocks_input, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken while result stalled")
    `DTLC_ASSERT_NOW(a_timeout_only_on, m_axis_tvalid && result_reg.ticks_to_off != 16'd0, result_reg.light_mode == dtlc_pkg::CODE_ON, "remaining time reported outside on state")
    `DTLC_ASSERT_NOW(a_blink_led_dark_off, m_axis_tvalid && result_reg.light_mode == dtlc_pkg::CODE_OFF, !result_reg.main_led, "main led lit in off state")

endmodule

>>> verif/debounced_toggle_led_controller_check.sv
// result checker for the debounced toggle led controller: tracks register writes,
// predicts one result beat per accepted tick and compares it with the output stream
// depends on dtlc_pkg
`timescale 1ns / 1ps

module debounced_toggle_led_controller_check (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [dtlc_pkg::IDX_WIDTH-1:0] cfg_index,
    input  logic [dtlc_pkg::CFG_WIDTH-1:0] cfg_data,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // raw_button
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // main_led, green_led, light_mode, button_stable, presses,
    // blink_done_cycles, blink_goal, ticks_to_off, stuck_flag, mode_changed
    input  logic [dtlc_pkg::OUT_WIDTH-1:0] m_axis_tdata,
    output int                             errors,
    output int                             outstanding
);

    // register copies
    dtlc_pkg::count8_t deb_samples;
    dtlc_pkg::tick_t   blink_half;
    dtlc_pkg::count8_t blink_reps;
    dtlc_pkg::tick_t   stuck_lim;
    dtlc_pkg::tick_t   off_lim;
    dtlc_pkg::tick_t   warn_win;
    dtlc_pkg::tick_t   warn_half;

    // controller state copies
    dtlc_pkg::mode_code_t mode_q;
    dtlc_pkg::mode_code_t goal_q;
    dtlc_pkg::count8_t    cycles_done;
    dtlc_pkg::tick_t      blink_ticks;
    logic                 blink_ph;
    dtlc_pkg::tick_t      idle_ticks;
    dtlc_pkg::tick_t      held_ticks;
    logic                 stuck_q;
    dtlc_pkg::word16_t    press_tally;
    dtlc_pkg::tick_t      warn_ticks;
    logic                 warn_ph;
    logic                 stable_q;
    logic                 cand_q;
    dtlc_pkg::count8_t    agree;
    logic                 prev_stable;

    dtlc_pkg::result_t expected_ticks [$];

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic compare_field(input string name, input int unsigned got,
                                 input int unsigned want);
        if (got != want)
            flag_error($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    function automatic dtlc_pkg::tick_t bump_tick(input dtlc_pkg::tick_t v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic dtlc_pkg::result_t advance_tick(input logic raw);
        dtlc_pkg::result_t    r;
        dtlc_pkg::mode_code_t start_mode;
        logic                 led;
        logic                 fired;
        logic                 press;
        logic                 green;
        dtlc_pkg::tick_t      remain;
        start_mode = mode_q;
        fired      = 1'b0;
        remain     = '0;

        // blink sequence output
        if (mode_q == dtlc_pkg::CODE_BLINK)
        begin
            blink_ticks = bump_tick(blink_ticks);
            if (blink_ticks >= blink_half)
            begin
                blink_ticks = '0;
                blink_ph    = !blink_ph;
                if (!blink_ph && cycles_done != 8'hFF)
                    cycles_done = cycles_done + 1'b1;
                if (cycles_done >= blink_reps)
                begin
                    mode_q = goal_q;
                    led    = (mode_q == dtlc_pkg::CODE_ON);
                end
                else
                    led = !blink_ph;
            end
            else
                led = !blink_ph;
        end
        else
            led = (mode_q == dtlc_pkg::CODE_ON);

        // debounce and press
        if (raw == cand_q)
        begin
            if (agree < deb_samples)
                agree = agree + 1'b1;
        end
        else
        begin
            cand_q = raw;
            agree  = 8'd1;
        end
        if (agree >= deb_samples)
            stable_q = cand_q;
        press       = stable_q && !prev_stable && (mode_q != dtlc_pkg::CODE_BLINK);
        prev_stable = stable_q;

        // stuck button
        if (raw)
        begin
            if (held_ticks < stuck_lim)
                held_ticks = bump_tick(held_ticks);
            stuck_q = (held_ticks >= stuck_lim);
        end
        else
        begin
            held_ticks = '0;
            stuck_q    = 1'b0;
        end

        if (press)
            press_tally = press_tally + 1'b1;

        // idle timeout
        if (mode_q == dtlc_pkg::CODE_ON)
        begin
            if (press)
                idle_ticks = '0;
            else
            begin
                idle_ticks = bump_tick(idle_ticks);
                if (idle_ticks >= off_lim)
                begin
                    idle_ticks = '0;
                    mode_q     = dtlc_pkg::CODE_OFF;
                    fired      = 1'b1;
                    led        = 1'b0;
                end
            end
        end
        else
            idle_ticks = '0;

        if (!fired && press)
        begin
            goal_q      = (mode_q == dtlc_pkg::CODE_OFF) ? dtlc_pkg::CODE_ON
                                                         : dtlc_pkg::CODE_OFF;
            cycles_done = '0;
            blink_ticks = '0;
            blink_ph    = 1'b0;
            mode_q      = dtlc_pkg::CODE_BLINK;
        end

        // green warning blink
        if (mode_q == dtlc_pkg::CODE_ON && off_lim > idle_ticks)
            remain = off_lim - idle_ticks;
        if (mode_q == dtlc_pkg::CODE_ON && remain <= warn_win)
        begin
            warn_ticks = bump_tick(warn_ticks);
            if (warn_ticks >= warn_half)
            begin
                warn_ticks = '0;
                warn_ph    = !warn_ph;
            end
            green = !warn_ph;
        end
        else
        begin
            warn_ticks = '0;
            warn_ph    = 1'b0;
            green      = 1'b1;
        end

        r.main_led          = led;
        r.green_led         = green;
        r.light_mode        = mode_q;
        r.button_stable     = stable_q;
        r.presses           = press_tally;
        r.blink_done_cycles = cycles_done;
        r.blink_goal        = goal_q;
        r.ticks_to_off      = (mode_q == dtlc_pkg::CODE_ON) ? remain : '0;
        r.stuck_flag        = stuck_q;
        r.mode_changed      = (mode_q != start_mode);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        dtlc_pkg::result_t got;
        dtlc_pkg::result_t want;
        if (!rst_n)
        begin
            deb_samples <= dtlc_pkg::RST_DEBOUNCE_SAMPLES;
            blink_half  <= dtlc_pkg::RST_BLINK_HALF_TICKS;
            blink_reps  <= dtlc_pkg::RST_BLINK_CYCLES;
            stuck_lim   <= dtlc_pkg::RST_STUCK_LIMIT;
            off_lim     <= dtlc_pkg::RST_AUTO_OFF_LIMIT;
            warn_win    <= dtlc_pkg::RST_WARN_WINDOW;
            warn_half   <= dtlc_pkg::RST_WARN_HALF_TICKS;
            mode_q      <= dtlc_pkg::CODE_OFF;
            goal_q      <= dtlc_pkg::CODE_ON;
            cycles_done <= '0;
            blink_ticks <= '0;
            blink_ph    <= 1'b0;
            idle_ticks  <= '0;
            held_ticks  <= '0;
            stuck_q     <= 1'b0;
            press_tally <= '0;
            warn_ticks  <= '0;
            warn_ph     <= 1'b0;
            stable_q    <= 1'b0;
            cand_q      <= 1'b0;
            agree       <= '0;
            prev_stable <= 1'b0;
            expected_ticks.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    dtlc_pkg::REG_DEBOUNCE_SAMPLES: deb_samples = cfg_data[7:0];
                    dtlc_pkg::REG_BLINK_HALF_TICKS: blink_half  = cfg_data;
                    dtlc_pkg::REG_BLINK_CYCLES:     blink_reps  = cfg_data[7:0];
                    dtlc_pkg::REG_STUCK_LIMIT:      stuck_lim   = cfg_data;
                    dtlc_pkg::REG_AUTO_OFF_LIMIT:   off_lim     = cfg_data;
                    dtlc_pkg::REG_WARN_WINDOW:      warn_win    = cfg_data;
                    dtlc_pkg::REG_WARN_HALF_TICKS:  warn_half   = cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = dtlc_pkg::result_t'(m_axis_tdata[dtlc_pkg::RESULT_WIDTH-1:0]);
                if (expected_ticks.size() == 0)
                    flag_error("result beat with no tick pending");
                else
                begin
                    want = expected_ticks.pop_front();
                    compare_field("main_led", got.main_led, want.main_led);
                    compare_field("green_led", got.green_led, want.green_led);
                    compare_field("light_mode", got.light_mode, want.light_mode);
                    compare_field("button_stable", got.button_stable, want.button_stable);
                    compare_field("presses", got.presses, want.presses);
                    compare_field("blink_done_cycles", got.blink_done_cycles,
                                  want.blink_done_cycles);
                    compare_field("blink_goal", got.blink_goal, want.blink_goal);
                    compare_field("ticks_to_off", got.ticks_to_off, want.ticks_to_off);
                    compare_field("stuck_flag", got.stuck_flag, want.stuck_flag);
                    compare_field("mode_changed", got.mode_changed, want.mode_changed);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_ticks.push_back(advance_tick(s_axis_tdata[0]));
            outstanding <= expected_ticks.size();
        end
    end

endmodule

>>> verif/debounced_toggle_led_controller_tb.sv
// testbench top for the debounced toggle led controller: drives button ticks in
// phases of register settings with random idling and gives the verdict
// depends on dtlc_pkg, the controller and debounced_toggle_led_controller_check
`timescale 1ns / 1ps

module debounced_toggle_led_controller_tb;

    localparam int LIMIT_CYCLES = 400000;
    localparam int LONG_HOLD    = 60;
    localparam logic [23:0] OPENING_TICKS = 24'b1101_0100_0000_0100_1000_1110;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [dtlc_pkg::IDX_WIDTH-1:0] cfg_index = '0;
    logic [dtlc_pkg::CFG_WIDTH-1:0] cfg_data = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [7:0]                     s_data = '0;  // raw_button
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    // main_led, green_led, light_mode, button_stable, presses,
    // blink_done_cycles, blink_goal, ticks_to_off, stuck_flag, mode_changed
    logic [dtlc_pkg::OUT_WIDTH-1:0] m_data;

    int          errors;
    int          outstanding;
    int          ticks_sent = 0;
    int unsigned cycles_run = 0;
    bit          gaps_on = 1'b1;
    bit          stalls_on = 1'b1;
    bit          hold_request = 1'b0;

    debounced_toggle_led_controller DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data)
    );

    debounced_toggle_led_controller_check u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .errors        (errors),
        .outstanding   (outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles_run++;
        if (cycles_run == LIMIT_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: long hold on request, short stalls, stretches of steady ready
    initial
    begin : sink
        forever
        begin
            if (hold_request)
            begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (stalls_on && $urandom_range(0, 4) == 0)
            begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    task automatic program_regs(input dtlc_pkg::word16_t d0, input dtlc_pkg::word16_t d1,
                                input dtlc_pkg::word16_t d2, input dtlc_pkg::word16_t d3,
                                input dtlc_pkg::word16_t d4, input dtlc_pkg::word16_t d5,
                                input dtlc_pkg::word16_t d6);
        dtlc_pkg::word16_t              vals [7];
        logic [dtlc_pkg::IDX_WIDTH-1:0] regs [7];
        vals = '{d0, d1, d2, d3, d4, d5, d6};
        regs = '{dtlc_pkg::REG_DEBOUNCE_SAMPLES, dtlc_pkg::REG_BLINK_HALF_TICKS,
                 dtlc_pkg::REG_BLINK_CYCLES, dtlc_pkg::REG_STUCK_LIMIT,
                 dtlc_pkg::REG_AUTO_OFF_LIMIT, dtlc_pkg::REG_WARN_WINDOW,
                 dtlc_pkg::REG_WARN_HALF_TICKS};
        for (int i = 0; i < 7; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_tick(input logic raw);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {7'd0, raw};
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        ticks_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // one press attempt: optional bounce, a hold sized to the debounce count
    // (sometimes too short or long enough to look stuck), then a quiet stretch
    task automatic press_episode(input int deb);
        int hold;
        int quiet;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) send_tick(1'($urandom_range(0, 1)));
        case ($urandom_range(0, 9))
            0:       hold = $urandom_range(1, (deb > 1) ? deb : 1);
            1:       hold = $urandom_range(20, 60);
            default: hold = deb + $urandom_range(0, 4);
        endcase
        if (hold < 1)
            hold = 1;
        repeat (hold) send_tick(1'b1);
        if ($urandom_range(0, 7) == 0)
            quiet = $urandom_range(20, 80);
        else
            quiet = $urandom_range(1, deb + 8);
        repeat (quiet) send_tick(1'b0);
    endtask

    task automatic run_presses(input int count, input int deb);
        int stop_at;
        stop_at = ticks_sent + count;
        while (ticks_sent < stop_at)
            press_episode(deb);
    endtask

    initial
    begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short thresholds: press, blink, settle, auto-off and warning in a few ticks
        program_regs(16'd1, 16'd1, 16'd1, 16'd2, 16'd4, 16'd3, 16'd1);
        for (int i = 0; i < 24; i++)
            send_tick(OPENING_TICKS[i]);
        wait_drained();

        // all thresholds zero
        program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_presses(30, 1);
        wait_drained();

        // all thresholds at maximum, one accepted press leaves a long blink running
        program_regs(16'd255, 16'hFFFF, 16'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (256) send_tick(1'b1);
        repeat (4) send_tick(1'b0);
        run_presses(5, 3);
        wait_drained();

        // lowered limits on running counters, plus a long output hold
        program_regs(16'd2, 16'd3, 16'd2, 16'd10, 16'd60, 16'd20, 16'd3);
        hold_request = 1'b1;
        run_presses(80, 2);
        wait_drained();

        // warning window covers the whole on time
        program_regs(16'd3, 16'd5, 16'd3, 16'd40, 16'd25, 16'd25, 16'd1);
        run_presses(60, 3);
        wait_drained();

        // steady streaming, no idling on either side
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        program_regs(16'd1, 16'd2, 16'd1, 16'd5, 16'd12, 16'd4, 16'd2);
        run_presses(50, 1);
        wait_drained();
        repeat (4) @(posedge clk);

        if (errors == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
